// ----- rtl/core/apf_pkg.sv -----
package apf_pkg;

   localparam int APID_BITS_DEFAULT = 11;
   localparam int COMMAND_BIT_POS   = 12;

   // operation codes
   localparam logic [3:0] OP_FILTER    = 4'd0;
   localparam logic [3:0] OP_SET_ALLOW = 4'd1;
   localparam logic [3:0] OP_SET_RATE  = 4'd2;
   localparam logic [3:0] OP_SET_ROUTE = 4'd3;
   localparam logic [3:0] OP_SET_DEPTH = 4'd4;
   localparam logic [3:0] OP_SET_ACK   = 4'd5;
   localparam logic [3:0] OP_STATUS    = 4'd6;
   localparam logic [3:0] OP_CLEAR     = 4'd7;
   localparam logic [3:0] OP_DEFAULTS  = 4'd8;

   // table entry without the phase, which lives in its own memory
   typedef struct packed {
      logic        pass;
      logic        ack;
      logic [7:0]  rate;
      logic [7:0]  route;
      logic [15:0] depth;
   } entry_type;

   localparam entry_type ENTRY_DEFAULT = '{
      pass:  1'b0,
      ack:   1'b1,
      rate:  8'd1,
      route: 8'd0,
      depth: 16'd0
   };

   // controller to datapath
   typedef struct packed {
      logic capture;        // latch the incoming transaction
      logic update;         // write back the modified entry and load the result
      logic sweep;          // walk the table, one entry per cycle
      logic sweep_defaults; // sweep also restores the entry fields
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_bulk;        // clear counters or restore defaults
      logic is_defaults;
      logic sweep_last;
   } status_type;

   typedef enum logic [4:0] {
      ST_SWEEP   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_READ    = 5'b00100,
      ST_UPDATE  = 5'b01000,
      ST_RESPOND = 5'b10000
   } state_type;

endpackage

// ----- rtl/core/apf_ctrl.sv -----
module apf_ctrl import apf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      defaults_ff, defaults_in;
   logic      reply_ff, reply_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         defaults_ff <= 1'b1;
         reply_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         defaults_ff <= defaults_in;
         reply_ff    <= reply_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      defaults_in = defaults_ff;
      reply_in    = reply_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = reply_ff ? ST_RESPOND : ST_IDLE;
               reply_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.is_bulk) begin
               state_in    = ST_SWEEP;
               defaults_in = status.is_defaults;
               reply_in    = 1'b1;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);

   assign cmd.capture        = (state_ff == ST_IDLE) && req_valid;
   assign cmd.update         = (state_ff == ST_UPDATE);
   assign cmd.sweep          = (state_ff == ST_SWEEP);
   assign cmd.sweep_defaults = defaults_ff;

endmodule

// ----- rtl/core/apf_datapath.sv -----
module apf_datapath import apf_pkg::*; #(
   parameter int APID_BITS = APID_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [3:0]  req_operation,
   input  logic [15:0] req_msg_id,
   input  logic [15:0] req_set_value,
   output logic        rsp_is_allowed,
   output logic        rsp_keep_sample,
   output logic [7:0]  rsp_route_out,
   output logic [15:0] rsp_depth_out,
   output logic        rsp_ack_ok,
   output logic        rsp_is_command,
   output logic [7:0]  rsp_rate_out,
   output logic [7:0]  rsp_phase_out
);

   localparam int DEPTH = 1 << APID_BITS;

   entry_type cfg_mem [DEPTH];
   logic [7:0] phase_mem [DEPTH];

   logic [3:0]           op_ff;
   logic [15:0]          id_ff;
   logic [15:0]          val_ff;
   logic [APID_BITS-1:0] index;
   logic [APID_BITS-1:0] sweep_cnt_ff, sweep_cnt_in;

   entry_type  cfg_rd_ff;
   logic [7:0] phase_rd_ff;

   entry_type  entry_upd;
   logic [7:0] phase_upd;
   logic [7:0] rate_eff;
   logic [8:0] phase_inc;
   logic       keep;

   logic                 cfg_we, phase_we;
   logic [APID_BITS-1:0] waddr;
   entry_type            cfg_wdata;
   logic [7:0]           phase_wdata;

   entry_type  rsp_entry_ff;
   logic [7:0] rsp_phase_ff;
   logic       rsp_keep_ff;
   logic       rsp_cmd_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         id_ff  <= req_msg_id;
         val_ff <= req_set_value;
      end
   end

   assign index = id_ff[APID_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   assign sweep_cnt_in = cmd.sweep ? sweep_cnt_ff + APID_BITS'(1) : sweep_cnt_ff;

   // entry modify
   always_comb begin
      entry_upd = cfg_rd_ff;
      phase_upd = phase_rd_ff;
      rate_eff  = (cfg_rd_ff.rate == 8'd0) ? 8'd1 : cfg_rd_ff.rate;
      phase_inc = {1'b0, phase_rd_ff} + 9'd1;
      keep      = 1'b0;
      case (op_ff)
         OP_FILTER: begin
            keep      = (phase_rd_ff == 8'd0);
            phase_upd = (phase_inc >= {1'b0, rate_eff}) ? 8'd0 : phase_inc[7:0];
         end
         OP_SET_ALLOW: entry_upd.pass  = val_ff[0];
         OP_SET_RATE: begin
            entry_upd.rate = val_ff[7:0];
            phase_upd      = 8'd0;
         end
         OP_SET_ROUTE: entry_upd.route = val_ff[7:0];
         OP_SET_DEPTH: entry_upd.depth = val_ff;
         OP_SET_ACK:   entry_upd.ack   = val_ff[0];
         OP_CLEAR:     phase_upd       = 8'd0;
         OP_DEFAULTS: begin
            entry_upd = ENTRY_DEFAULT;
            phase_upd = 8'd0;
         end
         default: ;
      endcase
   end

   // write port: item write-back or sweep
   always_comb begin
      if (cmd.sweep) begin
         waddr       = sweep_cnt_ff;
         cfg_we      = cmd.sweep_defaults;
         phase_we    = 1'b1;
         cfg_wdata   = ENTRY_DEFAULT;
         phase_wdata = 8'd0;
      end else begin
         waddr       = index;
         cfg_we      = cmd.update;
         phase_we    = cmd.update;
         cfg_wdata   = entry_upd;
         phase_wdata = phase_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (cfg_we) begin
         cfg_mem[waddr] <= cfg_wdata;
      end
      cfg_rd_ff <= cfg_mem[index];
   end

   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem[waddr] <= phase_wdata;
      end
      phase_rd_ff <= phase_mem[index];
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_entry_ff <= entry_upd;
         rsp_phase_ff <= phase_upd;
         rsp_keep_ff  <= keep;
         rsp_cmd_ff   <= id_ff[COMMAND_BIT_POS];
      end
   end

   assign status.is_bulk     = (op_ff == OP_CLEAR) || (op_ff == OP_DEFAULTS);
   assign status.is_defaults = (op_ff == OP_DEFAULTS);
   assign status.sweep_last  = &sweep_cnt_ff;

   assign rsp_is_allowed  = rsp_entry_ff.pass;
   assign rsp_keep_sample = rsp_keep_ff;
   assign rsp_route_out   = rsp_entry_ff.route;
   assign rsp_depth_out   = rsp_entry_ff.depth;
   assign rsp_ack_ok      = rsp_entry_ff.ack;
   assign rsp_is_command  = rsp_cmd_ff;
   assign rsp_rate_out    = rsp_entry_ff.rate;
   assign rsp_phase_out   = rsp_phase_ff;

endmodule

// ----- rtl/core/apid_packet_filter_table.sv -----
// rsp_valid rises once its accepted transaction has passed the read and update states
// one transaction at a time (table read/modify/write): no new request until the result is out
// clear counters and restore defaults add a table sweep over all 2^APID_BITS entries
// reset: synchronous, active high; afterwards a sweep over all 2^APID_BITS entries loads
// the default entries while req_stall stays high
module apid_packet_filter_table import apf_pkg::*; #(
   parameter int APID_BITS = APID_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [15:0] req_msg_id,
   input  logic [15:0] req_set_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_allowed,
   output logic        rsp_keep_sample,
   output logic [7:0]  rsp_route_out,
   output logic [15:0] rsp_depth_out,
   output logic        rsp_ack_ok,
   output logic        rsp_is_command,
   output logic [7:0]  rsp_rate_out,
   output logic [7:0]  rsp_phase_out
);

   // command and status between the sequencer and the table datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: sweep, idle, read, update, respond
   apf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table memories, entry modify logic and result register
   apf_datapath #(
      .APID_BITS (APID_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_msg_id      (req_msg_id),
      .req_set_value   (req_set_value),
      .rsp_is_allowed  (rsp_is_allowed),
      .rsp_keep_sample (rsp_keep_sample),
      .rsp_route_out   (rsp_route_out),
      .rsp_depth_out   (rsp_depth_out),
      .rsp_ack_ok      (rsp_ack_ok),
      .rsp_is_command  (rsp_is_command),
      .rsp_rate_out    (rsp_rate_out),
      .rsp_phase_out   (rsp_phase_out)
   );

   // one transaction in flight: no new request while a result is pending
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // a table sweep never overlaps an accepted request
   a_sweep_blocks : assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> req_stall)
      else $error("request accepted during table sweep");

   // exactly one result per transaction
   a_single_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result delivered twice");

   // the write-back happens only once the read data of the item is in hand
   a_update_after_capture : assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.capture, 2))
      else $error("entry update without a preceding request");

endmodule
